// ===== hdl/ats_pkg.sv =====
package ats_pkg;

	// width of the internal odd powers and terms, unsigned q0.32
	localparam int WIDE = 32;
	// quotient bits resolved per divider cycle
	localparam int DIV_STEP = 8;
	localparam int DIV_CYCLES = WIDE / DIV_STEP;
	// width of the stop threshold register, q0.16
	localparam int DELTA_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_ACCUM,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic div_start;
		logic accum;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic term_small;
		logic last_term;
	} status_t;

endpackage

// ===== hdl/ats_ctrl.sv =====
module ats_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ats_pkg::status_t status,
	output ats_pkg::cmd_t   cmd,
	output logic            busy
);
	import ats_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE:    state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				if (status.term_small || status.last_term) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DIV_START;
				end
			end
			ST_FINISH:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_SQUARE:    cmd.square = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV_WAIT:  cmd = '0;
			ST_ACCUM:     cmd.accum = 1'b1;
			ST_FINISH:    cmd.finish = 1'b1;
			default:      cmd = '0;
		endcase
	end

endmodule

// ===== hdl/ats_div.sv =====
module ats_div #(
	parameter int DIV_W = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ats_pkg::WIDE-1:0] dividend,
	input  logic [DIV_W-1:0]         divisor,
	output logic                     last,
	output logic [ats_pkg::WIDE-1:0] quotient
);
	import ats_pkg::*;

	localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	logic               running_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]   rem_q;
	logic [WIDE-1:0]    quo_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   rem_d;
	logic [WIDE-1:0]    quo_d;
	logic [DIV_W:0]     trial;
	logic [DIV_W-1:0]   r;
	logic [WIDE-1:0]    q;

	assign last = running_q && (cnt_q == CNT_W'(DIV_CYCLES - 1));
	assign quotient = quo_q;

	// restoring division, several quotient bits per cycle
	always_comb begin
		r = rem_q;
		q = quo_q;
		trial = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {r, q[WIDE-1]};
			q = {q[WIDE-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
				q[0] = 1'b1;
			end
			r = trial[DIV_W-1:0];
		end
		rem_d = r;
		quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			cnt_q <= '0;
		end else if (running_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (last) begin
				running_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (running_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

endmodule

// ===== hdl/ats_dp.sv =====
module ats_dp #(
	parameter int MAX_TERMS = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ats_pkg::cmd_t                        cmd,
	output ats_pkg::status_t                     status,
	input  logic signed [FRAC_BITS:0]            x_value,
	input  logic                                 cfg_wr_en,
	input  logic [ats_pkg::DELTA_W-1:0]          cfg_wr_data,
	output logic                                 done,
	output logic signed [FRAC_BITS+2:0]          arctanh_value,
	output logic [$clog2(MAX_TERMS+1)-1:0]       terms_used,
	output logic                                 limit_hit
);
	import ats_pkg::*;

	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int DIV_W = (MAX_TERMS > 1) ? $clog2(2 * MAX_TERMS) : 1;
	localparam int SUM_W = WIDE + CNT_W;
	localparam int SH_W  = SUM_W - WIDE + FRAC_BITS;
	localparam int OUT_W = FRAC_BITS + 3;
	localparam int CMP_W = (SH_W > OUT_W) ? SH_W : OUT_W;
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};

	logic [DELTA_W-1:0]     delta_q;
	logic                   neg_q;
	logic [FRAC_BITS-1:0]   mag_q;
	logic [WIDE-1:0]        x2_q;
	logic [WIDE-1:0]        power_q;
	logic [WIDE-1:0]        pnext_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       n_q;
	logic                   lim_q;
	logic                   done_q;
	logic signed [OUT_W-1:0] res_q;
	logic [CNT_W-1:0]       terms_q;
	logic                   limit_q;

	logic [FRAC_BITS:0]     neg_raw;
	logic [FRAC_BITS:0]     mag_full;
	logic [FRAC_BITS-1:0]   mag_d;
	logic [2*FRAC_BITS-1:0] sq;
	logic [WIDE-1:0]        x2_d;
	logic [2*WIDE-1:0]      prod;
	logic [DIV_W-1:0]       divisor;
	logic [WIDE-1:0]        term;
	logic                   div_last;
	logic [CMP_W-1:0]       sh_ext;
	logic [OUT_W-1:0]       res_mag;

	// magnitude of the argument, minus one clamped just below one
	assign neg_raw = -x_value;
	assign mag_full = x_value[FRAC_BITS] ? neg_raw : x_value;
	assign mag_d = mag_full[FRAC_BITS] ? {FRAC_BITS{1'b1}} : mag_full[FRAC_BITS-1:0];

	assign sq = mag_q * mag_q;
	if (2 * FRAC_BITS >= WIDE) begin : g_sq_down
		assign x2_d = sq[2*FRAC_BITS-1 -: WIDE];
	end else begin : g_sq_up
		assign x2_d = {sq, {(WIDE - 2 * FRAC_BITS){1'b0}}};
	end

	assign prod = power_q * x2_q;
	assign divisor = DIV_W'({n_q, 1'b1});

	ats_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(power_q),
		.divisor (divisor),
		.last    (div_last),
		.quotient(term)
	);

	assign status.div_done = div_last;
	assign status.term_small = term[WIDE-1 -: DELTA_W] < delta_q;
	assign status.last_term = n_q == CNT_W'(MAX_TERMS - 1);

	// truncate to output fraction, saturate, then apply the sign
	assign sh_ext = CMP_W'(sum_q[SUM_W-1:WIDE-FRAC_BITS]);
	assign res_mag = (sh_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : sh_ext[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= DELTA_W'(1);
			done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				delta_q <= cfg_wr_data;
			end
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		pnext_q <= prod[2*WIDE-1:WIDE];
		if (cmd.load) begin
			neg_q <= x_value[FRAC_BITS];
			mag_q <= mag_d;
			sum_q <= '0;
			n_q <= '0;
		end
		if (cmd.square) begin
			x2_q <= x2_d;
			power_q <= {mag_q, {(WIDE - FRAC_BITS){1'b0}}};
		end
		if (cmd.accum) begin
			sum_q <= sum_q + SUM_W'(term);
			n_q <= n_q + CNT_W'(1);
			lim_q <= !status.term_small;
			power_q <= pnext_q;
		end
		if (cmd.finish) begin
			res_q <= neg_q ? -$signed(res_mag) : $signed(res_mag);
			terms_q <= n_q;
			limit_q <= lim_q;
		end
	end

	assign done = done_q;
	assign arctanh_value = res_q;
	assign terms_used = terms_q;
	assign limit_hit = limit_q;

endmodule

// ===== hdl/arctanh_series_evaluator.sv =====
// inverse hyperbolic tangent by its odd power series
//
// request channel: raise start with x_value (signed q1.FRAC_BITS) while busy is
// low; the request is taken at that edge and busy rises the cycle after.
// result channel: done is high for exactly one cycle with arctanh_value
// (signed q3.FRAC_BITS, saturated), terms_used and limit_hit. the receiver
// cannot stall, so done marks the result for that one cycle only.
// configuration: cfg_wr_en with cfg_wr_data writes the stop threshold
// (unsigned q0.16) at the edge; write only while busy is low.
// sequence: busy is low again in the cycle done is shown, so a new request can
// be taken at the edge that ends it. each term costs a divider load, the
// divider run (eight quotient bits per cycle of the shared divider) and an
// accumulate step; at most MAX_TERMS terms are summed per request.
// reset: arst_n clears the controller, the result strobe and sets the
// threshold back to one lsb.
module arctanh_series_evaluator #(
	parameter int MAX_TERMS = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [FRAC_BITS:0]         x_value,
	input  logic                              cfg_wr_en,
	input  logic [ats_pkg::DELTA_W-1:0]       cfg_wr_data,
	output logic                              done,
	output logic signed [FRAC_BITS+2:0]       arctanh_value,
	output logic [$clog2(MAX_TERMS+1)-1:0]    terms_used,
	output logic                              limit_hit
);
	import ats_pkg::*;

	localparam int CNT_W = $clog2(MAX_TERMS + 1);

	cmd_t    cmd;
	status_t status;
	logic    accept;

	// request taken only while the controller sits idle
	assign accept = start && !busy;

	// sequencer: load, square, then divide and accumulate per term
	ats_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	// powers, shared divider, running sum and result registers
	ats_dp #(
		.MAX_TERMS(MAX_TERMS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.x_value      (x_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.arctanh_value(arctanh_value),
		.terms_used   (terms_used),
		.limit_hit    (limit_hit)
	);

	// a taken request always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request taken but block not busy");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in progress");

	// term count stays within one and the limit
	a_terms_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (terms_used != '0) && (terms_used <= CNT_W'(MAX_TERMS)))
		else $error("terms_used out of range");

	// the limit flag only comes with the full term count
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && limit_hit) |-> (terms_used == CNT_W'(MAX_TERMS)))
		else $error("limit_hit without reaching the term limit");

endmodule
